// ===== rtl/core/qlc_pkg.sv =====
// ----------------------------------------------------------------------------
// qlc_pkg: shared types and codes of the quadratic coefficients unit
// Packed payload structs for the request and response channels, and the
// status codes carried in a response, and a 64-bit magnitude helper.
// ----------------------------------------------------------------------------
`default_nettype none

package qlc_pkg;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EQUAL = 2'd1;
   localparam logic [1:0] ST_SAT   = 2'd2;

   typedef struct packed {
      logic signed [15:0] x0;
      logic signed [15:0] y0;
      logic signed [15:0] x1;
      logic signed [15:0] y1;
      logic signed [15:0] x2;
      logic signed [15:0] y2;
   } req_type;

   typedef struct packed {
      logic signed [63:0] coef_const;
      logic signed [63:0] coef_linear;
      logic signed [63:0] coef_square;
      logic        [1:0]  status;
   } rsp_type;

   // Magnitude of a signed 64-bit value; the most negative value maps to 2^63.
   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      abs64 = v[63] ? (64'd0 - 64'(v)) : 64'(v);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/quadratic_lagrange_coefficients_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_lagrange_coefficients_unit: quadratic through three points
// Computes the fixed-point coefficients of the quadratic through three
// integer points, with a bit-per-stage pipelined divider for the rounding.
// ----------------------------------------------------------------------------
//
//  channel | ports                          | direction | payload
//  --------+--------------------------------+-----------+-------------------
//  request | req_valid req_ready req_payload| in        | x0 y0 x1 y1 x2 y2
//  response| rsp_valid rsp_ready rsp_payload| out       | coefficients, status
//
// One transfer is accepted every cycle unless stalled. The pipeline has four
// multiply/add stages, one divider setup stage, FRAC_BITS + 66 restoring
// division steps (one quotient bit per stage, three lanes side by side) and an
// output stage. Reset clears only the per-stage valid bits. Each stage holds
// its item while the next stage is full and stalled, so an empty stage still
// takes a new item and a stall neither drops nor repeats a transfer.
//
`default_nettype none

module quadratic_lagrange_coefficients_unit
   import qlc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   // Dividend is (|num| << (FRAC_BITS+1)) + |den|; divisor is 2|den| < 2^50.
   localparam int NW   = 66 + FRAC_BITS;
   localparam int RW   = 50;
   localparam int SH   = FRAC_BITS + 1;
   localparam int NSTG = NW + 6;

   typedef struct packed {
      logic               eq;
      logic signed [16:0] d01, d02, d12;
      logic signed [16:0] sx12, sx02, sx01;
      logic signed [31:0] p12, p02, p01;
      logic signed [15:0] y0, y1, y2;
   } s1_type;

   typedef struct packed {
      logic               eq;
      logic signed [33:0] dd;
      logic signed [16:0] d12;
      logic signed [33:0] n0, n1, n2;
      logic signed [16:0] sx12, sx02, sx01;
      logic signed [31:0] p12, p02, p01;
   } s2_type;

   typedef struct packed {
      logic               eq;
      logic signed [50:0] den;
      logic signed [35:0] nsq;
      logic signed [50:0] tl0, tl1, tl2;
      logic signed [65:0] tc0, tc1, tc2;
   } s3_type;

   typedef struct packed {
      logic               eq;
      logic signed [50:0] den;
      logic signed [63:0] nsq, nlin, ncon;
   } s4_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [NW-1:0] nq;
   } lane_type;

   typedef struct packed {
      logic          eq;
      logic [2:0]    neg;
      logic [RW-1:0] dvs;
      lane_type [2:0] ln;
   } dstg_type;

   // Per-stage valid bits and the ready chain that lets bubbles collapse.
   logic [NSTG-1:0] v_ff;
   logic [NSTG:0]   rdy;

   always_comb begin
      rdy[NSTG] = rsp_ready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         rdy[i] = !v_ff[i] || rdy[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (rdy[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = v_ff[NSTG-1];

   // Stage 1: differences, pair sums and pair products of the abscissas, and their equality flag.
   s1_type s1_in, s1_ff;
   always_comb begin
      s1_in.d01  = req_payload.x0 - req_payload.x1;
      s1_in.d02  = req_payload.x0 - req_payload.x2;
      s1_in.d12  = req_payload.x1 - req_payload.x2;
      s1_in.eq   = (req_payload.x0 == req_payload.x1) || (req_payload.x0 == req_payload.x2)
                   || (req_payload.x1 == req_payload.x2);
      s1_in.sx12 = req_payload.x1 + req_payload.x2;
      s1_in.sx02 = req_payload.x0 + req_payload.x2;
      s1_in.sx01 = req_payload.x0 + req_payload.x1;
      s1_in.p12  = req_payload.x1 * req_payload.x2;
      s1_in.p02  = req_payload.x0 * req_payload.x2;
      s1_in.p01  = req_payload.x0 * req_payload.x1;
      s1_in.y0   = req_payload.y0;
      s1_in.y1   = req_payload.y1;
      s1_in.y2   = req_payload.y2;
   end

   // Stage 2: scaled ordinates over the common denominator.
   s2_type s2_in, s2_ff;
   always_comb begin
      s2_in.eq   = s1_ff.eq;
      s2_in.dd   = s1_ff.d01 * s1_ff.d02;
      s2_in.d12  = s1_ff.d12;
      s2_in.n0   = s1_ff.y0 * s1_ff.d12;
      s2_in.n1   = -(s1_ff.y1 * s1_ff.d02);
      s2_in.n2   = s1_ff.y2 * s1_ff.d01;
      s2_in.sx12 = s1_ff.sx12;
      s2_in.sx02 = s1_ff.sx02;
      s2_in.sx01 = s1_ff.sx01;
      s2_in.p12  = s1_ff.p12;
      s2_in.p02  = s1_ff.p02;
      s2_in.p01  = s1_ff.p01;
   end

   // Stage 3: denominator and the weighted terms of each numerator.
   s3_type s3_in, s3_ff;
   always_comb begin
      s3_in.eq  = s2_ff.eq;
      s3_in.den = s2_ff.dd * s2_ff.d12;
      s3_in.nsq = s2_ff.n0 + s2_ff.n1 + s2_ff.n2;
      s3_in.tl0 = s2_ff.n0 * s2_ff.sx12;
      s3_in.tl1 = s2_ff.n1 * s2_ff.sx02;
      s3_in.tl2 = s2_ff.n2 * s2_ff.sx01;
      s3_in.tc0 = s2_ff.n0 * s2_ff.p12;
      s3_in.tc1 = s2_ff.n1 * s2_ff.p02;
      s3_in.tc2 = s2_ff.n2 * s2_ff.p01;
   end

   // Stage 4: the three numerators. The constant one always fits 64 bits.
   s4_type s4_in, s4_ff;
   logic signed [52:0] lin_sum;
   always_comb begin
      lin_sum     = s3_ff.tl0 + s3_ff.tl1 + s3_ff.tl2;
      s4_in.eq    = s3_ff.eq;
      s4_in.den   = s3_ff.den;
      s4_in.nsq   = 64'(s3_ff.nsq);
      s4_in.nlin  = -64'(lin_sum);
      s4_in.ncon  = 64'(s3_ff.tc0 + s3_ff.tc1 + s3_ff.tc2);
   end

   // Divider setup: magnitudes, signs and the rounding offset.
   dstg_type dv_in [0:NW];
   dstg_type dv_ff [0:NW];
   logic [63:0] dmag;
   logic [63:0] nmag [0:2];
   logic [2:0]  nsgn;
   always_comb begin
      dmag    = abs64(64'(s4_ff.den));
      nmag[0] = abs64(s4_ff.ncon);
      nmag[1] = abs64(s4_ff.nlin);
      nmag[2] = abs64(s4_ff.nsq);
      nsgn    = {s4_ff.nsq[63], s4_ff.nlin[63], s4_ff.ncon[63]};
      dv_in[0].eq  = s4_ff.eq;
      dv_in[0].dvs = {dmag[RW-2:0], 1'b0};
      for (int l = 0; l < 3; l++) begin
         dv_in[0].neg[l]    = nsgn[l] ^ s4_ff.den[50];
         dv_in[0].ln[l].rem = '0;
         dv_in[0].ln[l].nq  = (NW'(nmag[l]) << SH) + NW'(dmag);
      end
   end

   // Restoring division: each stage shifts in one dividend bit and emits one
   // quotient bit into the vacated low end of the same shift register.
   for (genvar j = 1; j <= NW; j++) begin : g_div
      logic [RW:0] trial [0:2];
      always_comb begin
         dv_in[j].eq  = dv_ff[j-1].eq;
         dv_in[j].neg = dv_ff[j-1].neg;
         dv_in[j].dvs = dv_ff[j-1].dvs;
         for (int l = 0; l < 3; l++) begin
            trial[l] = {dv_ff[j-1].ln[l].rem, dv_ff[j-1].ln[l].nq[NW-1]};
            if (trial[l] >= {1'b0, dv_ff[j-1].dvs}) begin
               dv_in[j].ln[l].rem = RW'(trial[l] - {1'b0, dv_ff[j-1].dvs});
               dv_in[j].ln[l].nq  = {dv_ff[j-1].ln[l].nq[NW-2:0], 1'b1};
            end else begin
               dv_in[j].ln[l].rem = trial[l][RW-1:0];
               dv_in[j].ln[l].nq  = {dv_ff[j-1].ln[l].nq[NW-2:0], 1'b0};
            end
         end
      end
   end

   // Output stage: apply sign, clamp to the 64-bit range, form status.
   rsp_type         rsp_in, rsp_ff;
   logic [63:0]     coef [0:2];
   logic [2:0]      sat;
   logic [NW-1:0]   q;
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         q = dv_ff[NW].ln[l].nq;
         if (!dv_ff[NW].neg[l]) begin
            sat[l]  = (q[NW-1:63] != '0);
            coef[l] = sat[l] ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
         end else begin
            sat[l]  = (q[NW-1:64] != '0) || (q[63] && (q[62:0] != '0));
            coef[l] = sat[l] ? 64'h8000_0000_0000_0000 : (64'd0 - q[63:0]);
         end
      end
      if (dv_ff[NW].eq) begin
         rsp_in.coef_const  = '0;
         rsp_in.coef_linear = '0;
         rsp_in.coef_square = '0;
         rsp_in.status      = ST_EQUAL;
      end else begin
         rsp_in.coef_const  = coef[0];
         rsp_in.coef_linear = coef[1];
         rsp_in.coef_square = coef[2];
         rsp_in.status      = (sat != '0) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0])     s1_ff <= s1_in;
      if (rdy[1])     s2_ff <= s2_in;
      if (rdy[2])     s3_ff <= s3_in;
      if (rdy[3])     s4_ff <= s4_in;
      for (int k = 0; k <= NW; k++) begin
         if (rdy[4+k]) dv_ff[k] <= dv_in[k];
      end
      if (rdy[NSTG-1]) rsp_ff <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // Equal abscissas always come out with all coefficients cleared.
   a_equal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_EQUAL |->
         rsp_payload.coef_const == '0 && rsp_payload.coef_linear == '0
         && rsp_payload.coef_square == '0)
      else $error("equal-abscissa response with nonzero coefficients");

   // A response that is not taken keeps its stage, so the one behind it stalls.
   a_hold_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && v_ff[NSTG-2] |-> !rdy[NSTG-2])
      else $error("pipeline advanced into a stalled output stage");

   // An empty first stage always takes a request.
   a_entry_free: assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> req_ready)
      else $error("request refused with an empty entry stage");
`endif

endmodule

`default_nettype wire
